FILE: hdl/blr_pkg.sv
// Package for the Bresenham line rasterizer core.
// Holds field widths, reset values, operation and register codes, and the line setup struct.
// Used by blr_setup and bresenham_line_rasterizer_core; depends on nothing.
`default_nettype none

package blr_pkg;

	localparam int COORD_W = 12;
	localparam int COLOR_W = 16;
	localparam int DELTA_W = 13;
	localparam int ERR_W   = 14;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;

	localparam logic [COORD_W-1:0] RESET_WIDTH  = 12'd240;
	localparam logic [COORD_W-1:0] RESET_HEIGHT = 12'd320;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0]      major_pos;
		logic [COORD_W-1:0]      minor_pos;
		logic [COORD_W-1:0]      major_end;
		logic signed [ERR_W-1:0] error_term;
		logic [DELTA_W-1:0]      delta_major;
		logic [DELTA_W-1:0]      delta_minor;
		logic                    minor_down;
		logic                    steep_line;
	} line_setup_t;

endpackage

`default_nettype wire

FILE: hdl/blr_setup.sv
// Line setup logic: picks the major axis, orders the endpoints and derives the walk terms.
// Purely combinational; depends on blr_pkg.
`default_nettype none

module blr_setup
	import blr_pkg::*;
(
	input  wire logic [COORD_W-1:0] start_x,
	input  wire logic [COORD_W-1:0] start_y,
	input  wire logic [COORD_W-1:0] end_x,
	input  wire logic [COORD_W-1:0] end_y,
	output line_setup_t             setup
);

	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;
	logic               steep;
	logic [COORD_W-1:0] a0;
	logic [COORD_W-1:0] b0;
	logic [COORD_W-1:0] a1;
	logic [COORD_W-1:0] b1;
	logic [COORD_W-1:0] lo_a;
	logic [COORD_W-1:0] lo_b;
	logic [COORD_W-1:0] hi_a;
	logic [COORD_W-1:0] hi_b;
	logic [COORD_W-1:0] d_major;
	logic [COORD_W-1:0] d_minor;

	always_comb begin
		dx    = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
		dy    = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
		steep = dy > dx;

		if (steep) begin
			a0 = start_y;
			b0 = start_x;
			a1 = end_y;
			b1 = end_x;
		end else begin
			a0 = start_x;
			b0 = start_y;
			a1 = end_x;
			b1 = end_y;
		end

		if (a0 > a1) begin
			lo_a = a1;
			lo_b = b1;
			hi_a = a0;
			hi_b = b0;
		end else begin
			lo_a = a0;
			lo_b = b0;
			hi_a = a1;
			hi_b = b1;
		end

		d_major = hi_a - lo_a;
		d_minor = (hi_b >= lo_b) ? (hi_b - lo_b) : (lo_b - hi_b);

		setup.major_pos   = lo_a;
		setup.minor_pos   = lo_b;
		setup.major_end   = hi_a;
		setup.delta_major = {1'b0, d_major};
		setup.delta_minor = {1'b0, d_minor};
		setup.error_term  = $signed({3'b000, d_major[COORD_W-1:1]});
		setup.minor_down  = !(lo_b < hi_b);
		setup.steep_line  = steep;
	end

endmodule

`default_nettype wire

FILE: hdl/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer core with screen clipping, top level.
// A start transaction on the input stream sets up a line; each advance transaction then
// produces one pixel transaction on the output stream until the last pixel of the line.
// Screen width and height are set through a plain write port (index 0 width, 1 height).
// Input tdata carries start_x, start_y, end_x, end_y, color; tuser carries the opcode.
// Output tdata carries pixel_x, pixel_y, pixel_color; tuser carries on_screen; tlast marks
// the final pixel of the line.
// Each transaction is taken into an input register and then handled against the line state;
// a pixel goes into the output register when its advance is handled, and is presented from there.
// One transaction is accepted per cycle, set by the state update, unless the output stalls.
// A start or an advance while no line is active produces no output.
// When the receiver stalls, the output register holds the pixel and the input register
// fills; after that the input stream is stalled as well, and nothing is lost.
// Reset clears the line state to idle and sets the screen to 240 by 320 pixels.
`default_nettype none

module bresenham_line_rasterizer_core
	import blr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_addr,
	input  wire logic [COORD_W-1:0]    cfg_wdata,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y, color
	input  wire logic [0:0]            s_tuser,   // op
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y, pixel_color
	output      logic [0:0]            m_tuser,   // on_screen
	output      logic                  m_tlast
);

	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;

	logic                 valid_s1;
	logic                 op_s1;
	logic [IN_DATA_W-1:0] data_s1;

	logic [COORD_W-1:0]      major_pos_q;
	logic [COORD_W-1:0]      minor_pos_q;
	logic [COORD_W-1:0]      major_end_q;
	logic signed [ERR_W-1:0] error_term_q;
	logic [DELTA_W-1:0]      delta_major_q;
	logic [DELTA_W-1:0]      delta_minor_q;
	logic                    minor_down_q;
	logic                    steep_line_q;
	logic                    busy_q;
	logic [COLOR_W-1:0]      line_color_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_user_q;
	logic                  out_last_q;

	line_setup_t             setup;
	logic                    is_start;
	logic                    is_pixel;
	logic                    s1_move;
	logic                    fin;
	logic [COORD_W-1:0]      px;
	logic [COORD_W-1:0]      py;
	logic                    vis;
	logic signed [ERR_W-1:0] err_sub;
	logic signed [ERR_W-1:0] err_next;
	logic [COORD_W-1:0]      minor_next;

	blr_setup u_setup (
		.start_x (data_s1[11:0]),
		.start_y (data_s1[23:12]),
		.end_x   (data_s1[35:24]),
		.end_y   (data_s1[47:36]),
		.setup   (setup)
	);

	always_comb begin
		is_start = valid_s1 && (op_s1 == OP_START);
		is_pixel = valid_s1 && (op_s1 == OP_ADVANCE) && busy_q;
		s1_move  = valid_s1 && (!is_pixel || !out_valid_q || m_tready);
		s_tready = !valid_s1 || s1_move;

		px  = steep_line_q ? minor_pos_q : major_pos_q;
		py  = steep_line_q ? major_pos_q : minor_pos_q;
		fin = major_pos_q == major_end_q;
		vis = (px < width_q) && (py < height_q);

		err_sub = error_term_q - $signed({1'b0, delta_minor_q});
		if (err_sub < 0) begin
			err_next   = err_sub + $signed({1'b0, delta_major_q});
			minor_next = minor_down_q ? (minor_pos_q - 1'b1) : (minor_pos_q + 1'b1);
		end else begin
			err_next   = err_sub;
			minor_next = minor_pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser[0];
			data_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q   <= '0;
			minor_pos_q   <= '0;
			major_end_q   <= '0;
			error_term_q  <= '0;
			delta_major_q <= '0;
			delta_minor_q <= '0;
			minor_down_q  <= 1'b0;
			steep_line_q  <= 1'b0;
			busy_q        <= 1'b0;
			line_color_q  <= '0;
		end else if (s1_move) begin
			if (is_start) begin
				major_pos_q   <= setup.major_pos;
				minor_pos_q   <= setup.minor_pos;
				major_end_q   <= setup.major_end;
				error_term_q  <= setup.error_term;
				delta_major_q <= setup.delta_major;
				delta_minor_q <= setup.delta_minor;
				minor_down_q  <= setup.minor_down;
				steep_line_q  <= setup.steep_line;
				line_color_q  <= data_s1[63:48];
				busy_q        <= 1'b1;
			end else if (is_pixel) begin
				if (fin) begin
					busy_q <= 1'b0;
				end else begin
					error_term_q <= err_next;
					minor_pos_q  <= minor_next;
					major_pos_q  <= major_pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move && is_pixel) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && is_pixel) begin
			out_data_q <= {line_color_q, py, px};
			out_user_q <= vis;
			out_last_q <= fin;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_user_q;
	assign m_tlast    = out_last_q;

endmodule

`default_nettype wire
